/* src/teg_pkg.sv */
// Shared types, constants and command codes of the thermal erosion grid unit.
package teg_pkg;

	localparam int MAX_WIDTH_DEF   = 256;
	localparam int MAX_HEIGHT_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int DIM_W     = 9;
	localparam int PASS_W    = 16;
	localparam int TALUS_W   = 15;
	localparam int INDEX_W   = 16;
	localparam int VALUE_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Request codes
	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_RUN   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASSES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TALUS  = 2'd3;

	// Datapath operations
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_RD_C  = 3'd1;
	localparam logic [2:0] OP_RD_N  = 3'd2;
	localparam logic [2:0] OP_WR_C  = 3'd3;
	localparam logic [2:0] OP_WR_N  = 3'd4;
	localparam logic [2:0] OP_HOST  = 3'd5;

	// Controller to datapath command
	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  nb;      // neighbor: up, down, left, right
		logic        clear;   // reset best-drop search for a new cell
		logic        load_c;  // capture center from read data
		logic        eval_n;  // compare neighbor from read data
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic        slide;   // best drop exceeds talus
	} stat_t;

endpackage

/* src/thermal_erosion_grid_unit.sv */
// Top level of the thermal erosion grid unit.
// Write items give no reply; a read reply is registered through read_pend_q and
// the output register, and a pending read holds off the next request.
// A run visits each interior cell once per pass: read center, evaluate neighbors,
// decide, and on a slide rewrite center and best neighbor; a done reply ends it.
// Input is stalled during a run. Reset clears control state and registers to
// their defaults; the height memory holds undefined data until written.
module thermal_erosion_grid_unit import teg_pkg::*; #(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // sample_index[15:0], sample_value[31:16]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // reply_value[15:0]
	output logic        m_tuser,   // reply_kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [DIM_W-1:0]   width_q, height_q;
	logic [PASS_W-1:0]  passes_q;
	logic [TALUS_W-1:0] talus_q;
	logic [CW:0]        w_eff;
	logic [RW:0]        h_eff;
	cmd_t               cmd;
	stat_t              stat;
	logic [CW-1:0]      col;
	logic [RW-1:0]      row;
	logic               done_pulse, host_pulse, rd_ok, read_pend_q;
	logic [VALUE_W-1:0] rd_value;

	assign cfg_ready = 1'b1;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256; height_q <= 9'd256; passes_q <= 16'd1; talus_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_PASSES: passes_q <= cfg_data;
				REG_TALUS:  talus_q  <= cfg_data[TALUS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp dimensions to the store; a zero dimension becomes one
	always_comb begin
		if (width_q == 0) w_eff = (CW+1)'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = (CW+1)'(MAX_WIDTH);
		else w_eff = (CW+1)'(width_q);
		if (height_q == 0) h_eff = (RW+1)'(1);
		else if (32'(height_q) > MAX_HEIGHT) h_eff = (RW+1)'(MAX_HEIGHT);
		else h_eff = (RW+1)'(height_q);
	end

	teg_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_type(s_tuser),
		.w_eff, .h_eff, .passes(passes_q), .col, .row, .cmd, .stat,
		.done_pulse, .host_pulse, .out_busy((m_tvalid && !m_tready) || read_pend_q)
	);

	teg_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
		.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk, .arst_n, .cmd, .stat, .w_eff, .col, .row, .talus(talus_q),
		.in_type(s_tuser), .in_index(s_tdata[15:0]), .in_value(s_tdata[31:16]),
		.rd_ok, .rd_value
	);

	// Output register: a read reply is registered after read_pend_q, or a done reply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0; m_tuser <= 1'b0; m_tdata <= '0; read_pend_q <= 1'b0;
		end else begin
			read_pend_q <= host_pulse && (s_tuser == REQ_READ);
			if (read_pend_q) begin
				m_tvalid <= 1'b1; m_tuser <= 1'b0;
				m_tdata <= rd_ok ? rd_value : '0;
			end else if (done_pulse) begin
				m_tvalid <= 1'b1; m_tuser <= 1'b1; m_tdata <= '0;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 16'd0) else $error("done carries data");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready) else $error("accept while output stalled");
	a_read_reply: assert property (@(posedge clk) disable iff (!arst_n)
		read_pend_q |=> m_tvalid && !m_tuser) else $error("read reply lost");

endmodule

/* src/teg_ctrl.sv */
// Controller state machine for host requests and the erosion walk.
module teg_ctrl import teg_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int CW = $clog2(MAX_WIDTH),
	parameter int RW = $clog2(MAX_HEIGHT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_type,
	input  logic [CW:0]       w_eff,
	input  logic [RW:0]       h_eff,
	input  logic [PASS_W-1:0] passes,
	output logic [CW-1:0]     col,
	output logic [RW-1:0]     row,
	output cmd_t              cmd,
	input  stat_t             stat,
	output logic              done_pulse,
	output logic              host_pulse,
	input  logic              out_busy
);

	localparam logic [3:0] S_IDLE = 4'd0, S_RC = 4'd1, S_WC = 4'd2, S_RN = 4'd3,
		S_EN = 4'd4, S_DEC = 4'd5, S_RB = 4'd7, S_WB = 4'd8,
		S_NEXT = 4'd10, S_DONE = 4'd11;

	logic [3:0]        state_q;
	logic [PASS_W-1:0] pass_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [1:0]        nb_q;
	logic              last_col, last_row, last_pass;

	assign col = col_q;
	assign row = row_q;
	assign last_col  = ({1'b0, col_q} + 2'd2) >= w_eff;
	assign last_row  = ({1'b0, row_q} + 2'd2) >= h_eff;
	assign last_pass = (pass_q + 1'b1) >= passes;
	assign in_ready  = (state_q == S_IDLE) && !out_busy;
	assign host_pulse = in_valid && in_ready && (in_type != REQ_RUN);
	assign done_pulse = (state_q == S_DONE) && !out_busy;

	// Drive datapath command per state
	always_comb begin
		cmd = '0;
		cmd.nb = nb_q;
		case (state_q)
			S_IDLE: if (host_pulse) cmd.op = OP_HOST;
			S_RC:   cmd.op = OP_RD_C;
			S_WC:   begin cmd.load_c = 1'b1; cmd.clear = 1'b1; cmd.op = OP_RD_N; end
			S_RN:   cmd.op = OP_RD_N;
			S_EN:   begin cmd.eval_n = 1'b1; if (nb_q != 2'd3) cmd.op = OP_RD_N; end
			S_DEC:  if (stat.slide) cmd.op = OP_WR_C;
			S_RB:   cmd.op = OP_RD_N;
			S_WB:   cmd.op = OP_WR_N;
			default: ;
		endcase
		if (state_q == S_EN && nb_q != 2'd3) cmd.nb = nb_q + 2'd1;
		if (state_q == S_WC) cmd.nb = 2'd0;
	end

	// Sequence cells, neighbors and passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q  <= '0;
			col_q   <= '0;
			row_q   <= '0;
			nb_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid && in_ready && in_type == REQ_RUN) begin
					pass_q <= '0;
					row_q  <= RW'(1);
					col_q  <= CW'(1);
					if (w_eff >= 3 && h_eff >= 3 && passes != 0) state_q <= S_RC;
					else state_q <= S_DONE;
				end
				S_RC: state_q <= S_WC;
				S_WC: begin nb_q <= 2'd0; state_q <= S_EN; end
				S_RN: state_q <= S_EN;
				S_EN: if (nb_q == 2'd3) state_q <= S_DEC;
					else nb_q <= nb_q + 2'd1;
				S_DEC: state_q <= stat.slide ? S_RB : S_NEXT;
				S_RB:  state_q <= S_WB;
				S_WB:  state_q <= S_NEXT;
				S_NEXT: begin
					nb_q <= 2'd0;
					state_q <= S_RC;
					if (!last_col) col_q <= col_q + 1'b1;
					else begin
						col_q <= CW'(1);
						if (!last_row) row_q <= row_q + 1'b1;
						else begin
							row_q <= RW'(1);
							if (last_pass) state_q <= S_DONE;
							else pass_q <= pass_q + 1'b1;
						end
					end
				end
				S_DONE: if (!out_busy) begin
					state_q <= S_IDLE;
					pass_q <= '0; row_q <= '0; col_q <= '0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/teg_dp.sv */
// Datapath: height memory, drop search and slide arithmetic.
module teg_dp import teg_pkg::*; #(
	parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int CW = $clog2(MAX_WIDTH),
	parameter int RW = $clog2(MAX_HEIGHT),
	parameter int AW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output stat_t               stat,
	input  logic [CW:0]         w_eff,
	input  logic [CW-1:0]       col,
	input  logic [RW-1:0]       row,
	input  logic [TALUS_W-1:0]  talus,
	input  logic [1:0]          in_type,
	input  logic [INDEX_W-1:0]  in_index,
	input  logic signed [VALUE_W-1:0] in_value,
	output logic                rd_ok,
	output logic [VALUE_W-1:0]  rd_value
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int SB = SAMPLE_BITS;
	localparam logic signed [SB+1:0] SMAX = (SB+2)'((64'sd1 <<< (SB-1)) - 1);
	localparam logic signed [SB+1:0] SMIN = -SMAX - 1;

	logic signed [SB-1:0] mem [DEPTH];
	logic signed [SB-1:0] rdata_q;
	logic [AW-1:0]        raddr_q;
	logic [AW-1:0]        here, nb_addr, best_q, addr;
	logic signed [SB-1:0] h_q;
	logic signed [SB:0]   drop, best_drop_q, nb_drop;
	logic signed [SB+1:0] excess, amt, wsum;
	logic signed [SB-1:0] wdata;
	logic                 we;
	logic signed [SB-1:0] host_val;

	function automatic logic signed [SB-1:0] clamp(input logic signed [SB+1:0] v);
		if (v > SMAX) return SMAX[SB-1:0];
		if (v < SMIN) return SMIN[SB-1:0];
		return v[SB-1:0];
	endfunction

	// Cell and neighbor addresses
	assign here = AW'(row * w_eff + col);
	always_comb begin
		case (cmd.nb)
			2'd0: nb_addr = here - AW'(w_eff);
			2'd1: nb_addr = here + AW'(w_eff);
			2'd2: nb_addr = here - 1'b1;
			default: nb_addr = here + 1'b1;
		endcase
	end

	// Slide amount from best drop
	assign excess = (SB+2)'(best_drop_q) - (SB+2)'(signed'({1'b0, talus}));
	assign amt = excess >>> 1;
	assign stat.slide = excess > 0;
	assign nb_drop = (SB+1)'(h_q) - (SB+1)'(rdata_q);
	assign drop = best_drop_q;
	assign wsum = (SB+2)'(rdata_q) + amt;

	if (SB >= VALUE_W) begin : g_wide
		assign host_val = SB'(in_value);
	end else begin : g_narrow
		logic signed [VALUE_W-1:0] lim_hi, lim_lo;
		assign lim_hi = VALUE_W'(SMAX);
		assign lim_lo = VALUE_W'(SMIN);
		assign host_val = (in_value > lim_hi) ? SMAX[SB-1:0] :
			(in_value < lim_lo) ? SMIN[SB-1:0] : in_value[SB-1:0];
	end

	// Memory port select
	always_comb begin
		we = 1'b0; addr = here; wdata = host_val;
		case (cmd.op)
			OP_RD_C: addr = here;
			OP_RD_N: addr = nb_addr;
			OP_WR_C: begin we = 1'b1; addr = here; wdata = clamp((SB+2)'(h_q) - amt); end
			OP_WR_N: begin we = 1'b1; addr = best_q; wdata = clamp(wsum); end
			OP_HOST: begin
				addr = AW'(in_index);
				we = (in_type == REQ_WRITE) && ({16'd0, in_index} < 32'(DEPTH));
			end
			default: we = 1'b0;
		endcase
		if (cmd.op == OP_RD_N && cmd.eval_n == 1'b0 && cmd.load_c == 1'b0) addr = best_q;
	end

	// Single-port memory with registered read; keep the address of the read data
	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata_q <= mem[addr];
		raddr_q <= addr;
	end

	// Center capture and best neighbor search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_drop_q <= '0;
			best_q <= '0;
			h_q <= '0;
			rd_ok <= 1'b0;
		end else begin
			rd_ok <= (cmd.op == OP_HOST) && ({16'd0, in_index} < 32'(DEPTH));
			if (cmd.load_c) h_q <= rdata_q;
			if (cmd.clear) best_drop_q <= '0;
			if (cmd.eval_n && nb_drop > drop) begin
				best_drop_q <= nb_drop;
				best_q <= raddr_q;
			end
		end
	end

	assign rd_value = VALUE_W'(rdata_q);

endmodule
